@@ hw/rtl/huffman_tree_walk_decoder_core_defines.svh @@
// Assertion helpers shared by the queue and back-end modules.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define HTWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be seen outside reset.
`define HTWD_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

@@ hw/rtl/htwd_pkg.sv @@
package htwd_pkg;

   // table and length sizing
   localparam int NODE_COUNT  = 255;
   localparam int LENGTH_BITS = 24;
   localparam int NODE_BITS   = 8;
   localparam int NADDR_BITS  = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
   localparam int CHILD_BITS  = 9;
   localparam int ENTRY_BITS  = 2 * CHILD_BITS;
   localparam int BYTE_BITS   = 8;
   localparam int BITCNT_BITS = 3;

   // command queue sizing (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef logic [1:0]             op_type;
   typedef logic [NODE_BITS-1:0]   node_type;
   typedef logic [CHILD_BITS-1:0]  child_type;
   typedef logic [ENTRY_BITS-1:0]  entry_type;
   typedef logic [LENGTH_BITS-1:0] length_type;
   typedef logic [BYTE_BITS-1:0]   byte_type;
   typedef logic [BITCNT_BITS-1:0] bitcnt_type;

   // op codes on the request channel
   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_START = 2'd1;
   localparam op_type OP_BYTE  = 2'd2;

   localparam node_type   ROOT_NODE = 8'd254;
   localparam bitcnt_type BIT_LAST  = 3'd7;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_START,
      CMD_BYTE
   } cmd_kind_type;

   // classified command held in the queue
   typedef struct packed {
      cmd_kind_type kind;
      node_type     node_index;
      child_type    zero_child;
      child_type    one_child;
      byte_type     comp_byte;
      logic         final_byte;
      length_type   out_length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      byte_type out_byte;
      logic     has_byte;
      logic     chunk_done;
      logic     cut_short;
   } result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_SHORT
   } back_state_type;

endpackage

@@ hw/rtl/htwd_req_if.sv @@
interface htwd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  node_index;
   logic [8:0]  zero_child;
   logic [8:0]  one_child;
   logic [7:0]  comp_byte;
   logic        final_byte;
   logic [23:0] out_length;

   modport source (
      output valid, op, node_index, zero_child, one_child, comp_byte, final_byte,
             out_length,
      input  ready
   );
   modport sink (
      input  valid, op, node_index, zero_child, one_child, comp_byte, final_byte,
             out_length,
      output ready
   );
endinterface

@@ hw/rtl/htwd_rsp_if.sv @@
interface htwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       chunk_done;
   logic       cut_short;

   modport source (
      output valid, out_byte, has_byte, chunk_done, cut_short,
      input  ready
   );
   modport sink (
      input  valid, out_byte, has_byte, chunk_done, cut_short,
      output ready
   );
endinterface

@@ hw/rtl/htwd_front.sv @@
module htwd_front (
   input  logic                      clock,
   input  logic                      reset,
   htwd_req_if.sink                  req_ch,
   input  htwd_pkg::queue_status_type q_status,
   output logic                      push,
   output htwd_pkg::cmd_type         push_cmd
);

   logic              stage_valid_ff, stage_valid_in;
   htwd_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   htwd_pkg::cmd_type classed;
   logic              accept;
   logic              keep;

   // stage drains into the queue whenever there is room
   assign push     = stage_valid_ff && !q_status.full;
   assign push_cmd = stage_cmd_ff;
   assign req_ch.ready = !stage_valid_ff || push;
   assign accept   = req_ch.valid && req_ch.ready;

   // classify the incoming word; unused op codes are dropped here
   always_comb begin
      classed.kind       = htwd_pkg::CMD_LOAD;
      classed.node_index = req_ch.node_index;
      classed.zero_child = req_ch.zero_child;
      classed.one_child  = req_ch.one_child;
      classed.comp_byte  = req_ch.comp_byte;
      classed.final_byte = req_ch.final_byte;
      classed.out_length = htwd_pkg::length_type'(req_ch.out_length);
      keep = 1'b0;
      case (req_ch.op)
         htwd_pkg::OP_LOAD: begin
            classed.kind = htwd_pkg::CMD_LOAD;
            keep = accept;
         end
         htwd_pkg::OP_START: begin
            classed.kind = htwd_pkg::CMD_START;
            keep = accept;
         end
         htwd_pkg::OP_BYTE: begin
            classed.kind = htwd_pkg::CMD_BYTE;
            keep = accept;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // stage register next values
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_cmd_in   = stage_cmd_ff;
      if (keep) begin
         stage_valid_in = 1'b1;
         stage_cmd_in   = classed;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

@@ hw/rtl/htwd_queue.sv @@
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  htwd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output htwd_pkg::cmd_type          pop_cmd,
   output htwd_pkg::queue_status_type q_status
);

   htwd_pkg::cmd_type                  slot_ff [htwd_pkg::QUEUE_DEPTH];
   logic [htwd_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [htwd_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [htwd_pkg::QCNT_BITS-1:0]     count_ff, count_in;

   assign q_status.full  = count_ff == htwd_pkg::QCNT_BITS'(htwd_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign pop_cmd        = slot_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `HTWD_NEVER(a_q_no_overflow, clock, reset, push && q_status.full, "queue push while full")
   `HTWD_NEVER(a_q_no_underflow, clock, reset, pop && q_status.empty, "queue pop while empty")
   `HTWD_ASSERT(a_q_count_hold, clock, reset, !push && !pop |=> $stable(count_ff), "count moved")

endmodule

@@ hw/rtl/htwd_back.sv @@
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  htwd_pkg::queue_status_type q_status,
   input  htwd_pkg::cmd_type          pop_cmd,
   output logic                       pop,
   htwd_rsp_if.source                 rsp_ch
);

   // node table: one write port, one registered read port
   htwd_pkg::entry_type node_mem [htwd_pkg::NODE_COUNT];
   htwd_pkg::entry_type rd_entry_ff;
   logic                rd_oob_ff;
   logic                rd_en;
   htwd_pkg::node_type  rd_node;
   logic                mem_we;

   htwd_pkg::back_state_type state_ff, state_in;
   htwd_pkg::node_type       walk_node_ff, walk_node_in;
   htwd_pkg::length_type     bytes_out_ff, bytes_out_in;
   htwd_pkg::length_type     target_ff, target_in;
   logic                     decoding_ff, decoding_in;
   htwd_pkg::byte_type       byte_ff, byte_in;
   logic                     last_ff, last_in;
   htwd_pkg::bitcnt_type     bit_cnt_ff, bit_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   htwd_pkg::result_type     rsp_res_ff, rsp_res_in;
   logic                     emit;
   htwd_pkg::result_type     emit_res;

   logic                     out_free;
   logic                     take_cmd;
   htwd_pkg::entry_type      entry;
   htwd_pkg::child_type      child;
   logic                     is_leaf;
   logic                     last_bit;
   logic                     step;
   htwd_pkg::length_type     count_next;
   logic                     reach;

   // walk step decode
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign take_cmd   = !q_status.empty && out_free;
   assign entry      = rd_oob_ff ? '0 : rd_entry_ff;
   assign child      = byte_ff[bit_cnt_ff] ? entry[htwd_pkg::ENTRY_BITS-1:htwd_pkg::CHILD_BITS]
                                           : entry[htwd_pkg::CHILD_BITS-1:0];
   assign is_leaf    = !child[htwd_pkg::CHILD_BITS-1];
   assign last_bit   = bit_cnt_ff == htwd_pkg::BIT_LAST;
   assign step       = !is_leaf || out_free;
   assign count_next = bytes_out_ff + 1'b1;
   assign reach      = count_next == target_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htwd_pkg::BK_IDLE: begin
            if (take_cmd && pop_cmd.kind == htwd_pkg::CMD_BYTE && decoding_ff) begin
               state_in = htwd_pkg::BK_WALK;
            end
         end
         htwd_pkg::BK_WALK: begin
            if (step) begin
               if (is_leaf && reach) begin
                  state_in = htwd_pkg::BK_IDLE;
               end else if (last_bit) begin
                  state_in = last_ff ? htwd_pkg::BK_SHORT : htwd_pkg::BK_IDLE;
               end
            end
         end
         htwd_pkg::BK_SHORT: begin
            if (out_free) begin
               state_in = htwd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = htwd_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath controls per state
   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_node      = walk_node_ff;
      walk_node_in = walk_node_ff;
      bytes_out_in = bytes_out_ff;
      target_in    = target_ff;
      decoding_in  = decoding_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      bit_cnt_in   = bit_cnt_ff;
      emit         = 1'b0;
      emit_res     = '0;
      case (state_ff)
         htwd_pkg::BK_IDLE: begin
            if (take_cmd) begin
               pop = 1'b1;
               case (pop_cmd.kind)
                  htwd_pkg::CMD_LOAD: begin
                     mem_we = pop_cmd.node_index < htwd_pkg::NODE_BITS'(htwd_pkg::NODE_COUNT);
                  end
                  htwd_pkg::CMD_START: begin
                     target_in    = pop_cmd.out_length;
                     bytes_out_in = '0;
                     walk_node_in = htwd_pkg::ROOT_NODE;
                     if (pop_cmd.out_length == '0) begin
                        decoding_in         = 1'b0;
                        emit                = 1'b1;
                        emit_res.chunk_done = 1'b1;
                     end else begin
                        decoding_in = 1'b1;
                     end
                  end
                  htwd_pkg::CMD_BYTE: begin
                     // bytes seen while no chunk is open are dropped
                     if (decoding_ff) begin
                        rd_en      = 1'b1;
                        rd_node    = walk_node_ff;
                        byte_in    = pop_cmd.comp_byte;
                        last_in    = pop_cmd.final_byte;
                        bit_cnt_in = '0;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         htwd_pkg::BK_WALK: begin
            if (step) begin
               if (is_leaf) begin
                  emit                = 1'b1;
                  emit_res.out_byte   = child[htwd_pkg::BYTE_BITS-1:0];
                  emit_res.has_byte   = 1'b1;
                  emit_res.chunk_done = reach;
                  bytes_out_in        = count_next;
                  walk_node_in        = htwd_pkg::ROOT_NODE;
                  if (reach) begin
                     decoding_in = 1'b0;
                  end
               end else begin
                  walk_node_in = child[htwd_pkg::NODE_BITS-1:0];
               end
               // fetch the node for the next bit
               if (!(is_leaf && reach) && !last_bit) begin
                  rd_en      = 1'b1;
                  rd_node    = is_leaf ? htwd_pkg::ROOT_NODE : child[htwd_pkg::NODE_BITS-1:0];
                  bit_cnt_in = bit_cnt_ff + 1'b1;
               end
            end
         end
         htwd_pkg::BK_SHORT: begin
            if (out_free) begin
               emit                = 1'b1;
               emit_res.chunk_done = 1'b1;
               emit_res.cut_short  = 1'b1;
               decoding_in         = 1'b0;
               walk_node_in        = htwd_pkg::ROOT_NODE;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = emit_res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_res_ff.out_byte;
   assign rsp_ch.has_byte   = rsp_res_ff.has_byte;
   assign rsp_ch.chunk_done = rsp_res_ff.chunk_done;
   assign rsp_ch.cut_short  = rsp_res_ff.cut_short;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htwd_pkg::BK_IDLE;
         walk_node_ff <= htwd_pkg::ROOT_NODE;
         bytes_out_ff <= '0;
         target_ff    <= '0;
         decoding_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_node_ff <= walk_node_in;
         bytes_out_ff <= bytes_out_in;
         target_ff    <= target_in;
         decoding_ff  <= decoding_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      bit_cnt_ff <= bit_cnt_in;
      rsp_res_ff <= rsp_res_in;
   end

   // node table; nodes past the table read as zero children
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[pop_cmd.node_index[htwd_pkg::NADDR_BITS-1:0]] <=
            {pop_cmd.one_child, pop_cmd.zero_child};
      end
      if (rd_en) begin
         rd_entry_ff <= node_mem[rd_node[htwd_pkg::NADDR_BITS-1:0]];
         rd_oob_ff   <= rd_node >= htwd_pkg::NODE_BITS'(htwd_pkg::NODE_COUNT);
      end
   end

   `HTWD_ASSERT(a_walk_needs_chunk, clock, reset, state_ff == htwd_pkg::BK_WALK |-> decoding_ff, "walk outside a chunk")
   `HTWD_ASSERT(a_done_ends_chunk, clock, reset, emit && emit_res.chunk_done |=> !decoding_ff, "chunk still open after done")
   `HTWD_ASSERT(a_short_is_marker, clock, reset, emit && emit_res.cut_short |-> emit_res.chunk_done && !emit_res.has_byte, "bad short-end word")
   `HTWD_ASSERT(a_emit_has_room, clock, reset, emit |-> !rsp_valid_ff || rsp_ch.ready, "result overwritten")

endmodule

@@ hw/rtl/huffman_tree_walk_decoder_core.sv @@
// Huffman tree-walk decoder, least significant bit first.
// req_ch carries words: op 0 loads one table node (both 9-bit children),
// op 1 opens a chunk with its expected decoded length, op 2 is one compressed
// byte; op 3 is discarded. rsp_ch returns decoded bytes, each with has_byte
// set, plus chunk_done on the last word of a chunk and cut_short when the
// final compressed byte ran out before the expected length.
// Inside, a front stage registers and classifies each request word into a
// four-entry command queue; the back end pops commands and walks the table.
// A compressed byte is walked by first fetching the current node and then
// stepping through its bits in turn, because the single registered read port
// of the node table is chained bit to bit; no new command is popped until the
// byte is done. A request word is registered in the front stage and then held
// in the queue; the node read register and the result register lie between a
// byte's pop and rsp_ch valid. A zero-length start answers with one done word.
// Reset clears the control state: the walk sits at the root, no chunk is open,
// the queue is empty. The node table is not cleared and must be loaded first.
// When rsp_ch stalls, the result register holds and the walk pauses at the
// next leaf; the queue then fills and req_ch drops ready.
module huffman_tree_walk_decoder_core (
   input  logic        clock,
   input  logic        reset,
   htwd_req_if.sink    req_ch,
   htwd_rsp_if.source  rsp_ch
);

   logic                       push;
   htwd_pkg::cmd_type          push_cmd;
   logic                       pop;
   htwd_pkg::cmd_type          pop_cmd;
   htwd_pkg::queue_status_type q_status;

   htwd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   htwd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   htwd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
